// ===== rtl/text_terminal_character_writer_macros.svh =====
// Assertion macros for the text terminal character writer.
`ifndef TEXT_TERMINAL_CHARACTER_WRITER_MACROS_SVH
`define TEXT_TERMINAL_CHARACTER_WRITER_MACROS_SVH

// Property checked on every clock edge outside reset.
`define TTCW_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define TTCW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ttcw_pkg.sv =====
// Shared constants, types and helpers for the text terminal character writer.
package ttcw_pkg;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int COPY_COUNT = (ROWS - 1) * COLUMNS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);

    localparam int ACT_W   = 2;
    localparam int CHAR_W  = 8;
    localparam int COLOR_W = 8;
    localparam int IDX_W   = 11;
    localparam int COL_W   = 7;
    localparam int ROW_W   = 5;
    localparam int OFS_W   = 11;
    localparam int CELL_W  = 16;

    localparam logic [ACT_W-1:0] ACT_PUT   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd1;
    localparam logic [ACT_W-1:0] ACT_READ  = 2'd2;

    localparam logic [CHAR_W-1:0]  CODE_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0]  CODE_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0]  CODE_SPACE     = 8'd32;
    localparam logic [COLOR_W-1:0] RESET_COLOR    = 8'h0B;

    typedef struct packed {
        logic take;       // latch the offered item
        logic exec;       // decode and apply the latched item
        logic copy;       // one step of the scroll copy
        logic fill;       // one step of a blanking pass
        logic fill_init;  // blanking uses the reset color
        logic load;       // move the result into the output register
    } ttcw_cmd_t;

    typedef struct packed {
        logic op_clear;
        logic op_scroll;
        logic copy_last;
        logic fill_last;
        logic out_free;
    } ttcw_stat_t;

    function automatic logic [CELL_W-1:0] make_cell(input logic [COLOR_W-1:0] color,
                                                    input logic [CHAR_W-1:0] ch);
        make_cell = {color, ch};
    endfunction

endpackage

// ===== rtl/ttcw_ctrl.sv =====
// Sequencing state machine for the text terminal character writer.
module ttcw_ctrl
    import ttcw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  ttcw_stat_t stat,
    output ttcw_cmd_t  cmd,
    output logic       in_stall
);

    localparam logic [2:0] ST_INIT   = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_EXEC   = 3'd2;
    localparam logic [2:0] ST_SCROLL = 3'd3;
    localparam logic [2:0] ST_FILL   = 3'd4;
    localparam logic [2:0] ST_DONE   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_INIT:
            begin
                cmd.fill      = 1'b1;
                cmd.fill_init = 1'b1;
                if (stat.fill_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
                if (stat.op_clear)
                begin
                    state_next = ST_FILL;
                end
                else if (stat.op_scroll)
                begin
                    state_next = ST_SCROLL;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_SCROLL:
            begin
                cmd.copy = 1'b1;
                if (stat.copy_last)
                begin
                    state_next = ST_FILL;
                end
            end
            ST_FILL:
            begin
                cmd.fill = 1'b1;
                if (stat.fill_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

endmodule

// ===== rtl/ttcw_dpath.sv =====
// Screen store, cursor, sweep counter and output register of the terminal writer.
module ttcw_dpath
    import ttcw_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  ttcw_cmd_t           cmd,
    output ttcw_stat_t          stat,
    input  logic [ACT_W-1:0]    action,
    input  logic [CHAR_W-1:0]   char_code,
    input  logic [IDX_W-1:0]    cell_index,
    input  logic                cfg_write,
    input  logic [COLOR_W-1:0]  cfg_data,
    input  logic                out_stall,
    output logic                out_valid,
    output logic [COL_W-1:0]    cursor_column,
    output logic [ROW_W-1:0]    cursor_row,
    output logic [OFS_W-1:0]    cursor_offset,
    output logic [CELL_W-1:0]   read_entry,
    output logic                scrolled
);

    logic [CELL_W-1:0] mem [CELL_COUNT];

    logic [ACT_W-1:0]   action_reg;
    logic [CHAR_W-1:0]  char_reg;
    logic [IDX_W-1:0]   cell_reg;
    logic [COLOR_W-1:0] text_color_reg;
    logic [COL_W-1:0]   col_reg;
    logic [COL_W-1:0]   col_next;
    logic [ROW_W-1:0]   row_reg;
    logic [ROW_W-1:0]   row_next;
    logic [ADDR_W-1:0]  cnt_reg;
    logic [ADDR_W-1:0]  cnt_next;
    logic [CELL_W-1:0]  rd_data_reg;
    logic               scrolled_reg;
    logic               read_hit_reg;
    logic               out_valid_reg;
    logic [COL_W-1:0]   out_col_reg;
    logic [ROW_W-1:0]   out_row_reg;
    logic [OFS_W-1:0]   out_ofs_reg;
    logic [CELL_W-1:0]  out_entry_reg;
    logic               out_scrolled_reg;

    logic               is_put;
    logic               is_nl;
    logic               is_bs;
    logic               at_last_col;
    logic               at_last_row;
    logic               row_adv;
    logic               read_ok;
    logic [ADDR_W-1:0]  offset;
    logic [CELL_W-1:0]  blank;
    logic               we;
    logic [ADDR_W-1:0]  waddr;
    logic [CELL_W-1:0]  wdata;
    logic               re;
    logic [ADDR_W-1:0]  raddr;

    // Item decode
    assign is_put      = (action_reg == ACT_PUT);
    assign is_nl       = (char_reg == CODE_NEWLINE);
    assign is_bs       = (char_reg == CODE_BACKSPACE);
    assign at_last_col = (col_reg == COL_W'(COLUMNS - 1));
    assign at_last_row = (row_reg == ROW_W'(ROWS - 1));
    assign row_adv     = is_put && (is_nl || (!is_bs && at_last_col));
    assign read_ok     = (action_reg == ACT_READ) && (int'(cell_reg) < CELL_COUNT);
    assign offset      = ADDR_W'(row_reg) * ADDR_W'(COLUMNS) + ADDR_W'(col_reg);
    assign blank       = make_cell(text_color_reg, CODE_SPACE);

    assign stat.op_clear  = (action_reg == ACT_CLEAR);
    assign stat.op_scroll = row_adv && at_last_row;
    assign stat.copy_last = (cnt_reg == ADDR_W'(COPY_COUNT));
    assign stat.fill_last = (cnt_reg == ADDR_W'(CELL_COUNT - 1));
    assign stat.out_free  = !out_valid_reg || !out_stall;

    // Cursor
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cmd.exec)
        begin
            case (action_reg)
                ACT_PUT:
                begin
                    if (is_nl)
                    begin
                        col_next = '0;
                    end
                    else if (is_bs)
                    begin
                        if (col_reg != '0)
                        begin
                            col_next = col_reg - 1'b1;
                        end
                    end
                    else if (at_last_col)
                    begin
                        col_next = '0;
                    end
                    else
                    begin
                        col_next = col_reg + 1'b1;
                    end
                    if (row_adv && !at_last_row)
                    begin
                        row_next = row_reg + 1'b1;
                    end
                end
                ACT_CLEAR:
                begin
                    col_next = '0;
                    row_next = '0;
                end
                default:
                begin
                    col_next = col_reg;
                end
            endcase
        end
    end

    // Sweep counter: copy stops on the first bottom-row cell, where blanking starts
    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.exec)
        begin
            cnt_next = '0;
        end
        else if (cmd.copy)
        begin
            if (!stat.copy_last)
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
        else if (cmd.fill)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
    end

    // Store port selection
    always_comb
    begin
        we    = 1'b0;
        waddr = offset;
        wdata = blank;
        re    = 1'b0;
        raddr = ADDR_W'(cell_reg);
        if (cmd.exec)
        begin
            if (is_put && !is_nl)
            begin
                if (is_bs)
                begin
                    we    = (col_reg != '0);
                    waddr = offset - 1'b1;
                end
                else
                begin
                    we    = 1'b1;
                    wdata = make_cell(text_color_reg, char_reg);
                end
            end
            re = read_ok;
        end
        else if (cmd.copy)
        begin
            // read row below, write the cell read in the previous cycle
            we    = (cnt_reg != '0);
            waddr = cnt_reg - 1'b1;
            wdata = rd_data_reg;
            re    = !stat.copy_last;
            raddr = cnt_reg + ADDR_W'(COLUMNS);
        end
        else if (cmd.fill)
        begin
            we    = 1'b1;
            waddr = cnt_reg;
            wdata = cmd.fill_init ? make_cell(RESET_COLOR, CODE_SPACE) : blank;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rd_data_reg <= mem[raddr];
        end
    end

    // Item latch and result flags
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            action_reg <= action;
            char_reg   <= char_code;
            cell_reg   <= cell_index;
        end
        if (cmd.exec)
        begin
            scrolled_reg <= stat.op_scroll;
            read_hit_reg <= read_ok;
        end
        if (cmd.load)
        begin
            out_col_reg      <= col_reg;
            out_row_reg      <= row_reg;
            out_ofs_reg      <= OFS_W'(offset);
            out_entry_reg    <= read_hit_reg ? rd_data_reg : '0;
            out_scrolled_reg <= scrolled_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_color_reg <= RESET_COLOR;
            col_reg        <= '0;
            row_reg        <= '0;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                text_color_reg <= cfg_data;
            end
            col_reg <= col_next;
            row_reg <= row_next;
            cnt_reg <= cnt_next;
            if (cmd.load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign cursor_column = out_col_reg;
    assign cursor_row    = out_row_reg;
    assign cursor_offset = out_ofs_reg;
    assign read_entry    = out_entry_reg;
    assign scrolled      = out_scrolled_reg;

endmodule

// ===== rtl/text_terminal_character_writer.sv =====
// Top level of the text terminal character writer.
//
// Text-mode terminal with an 80x25 store of 16-bit cells (attribute in the high
// byte, character in the low byte) and a cursor. Each input item is a put (with
// newline and backspace handled as control codes), a clear or a read of one cell;
// each gives exactly one result with the cursor after the item, its linear offset
// for the display cursor registers, the read data and a scroll flag. The store is
// a single-port-write, single-port-read memory, so timing is set by passes over it:
// after reset a blanking pass over all ROWS*COLUMNS = 2000 cells runs with in_stall
// high. A plain put, newline, backspace or read passes through the accept, execute
// and load steps: its result is registered by the load, and the next item can be
// taken in the cycle after the load. A put or newline that runs past the last row
// adds a scroll that copies the lower rows up, then blanks the COLUMNS = 80 cells
// of the bottom row; a clear blanks all 2000 cells. A result waits in the load
// step for as long as the output register holds a stalled result. One item is in
// work at a time; the output register lets the next item enter while the previous
// result is stalled. Write text_color only while no item is in work: an item in
// work picks up the new color for whatever it writes after the write.
`include "text_terminal_character_writer_macros.svh"

module text_terminal_character_writer
    import ttcw_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // item input
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [ACT_W-1:0]    action,
    input  logic [CHAR_W-1:0]   char_code,
    input  logic [IDX_W-1:0]    cell_index,
    // text color register
    input  logic                cfg_write,
    input  logic [COLOR_W-1:0]  cfg_data,
    // result output
    output logic                out_valid,
    input  logic                out_stall,
    output logic [COL_W-1:0]    cursor_column,
    output logic [ROW_W-1:0]    cursor_row,
    output logic [OFS_W-1:0]    cursor_offset,
    output logic [CELL_W-1:0]   read_entry,
    output logic                scrolled
);

    ttcw_cmd_t  cmd;
    ttcw_stat_t stat;

    // Sequencer: init blanking, accept, execute, scroll/clear passes, result load
    ttcw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .stat     (stat),
        .cmd      (cmd),
        .in_stall (in_stall)
    );

    // Screen memory, cursor and output register
    ttcw_dpath u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .action        (action),
        .char_code     (char_code),
        .cell_index    (cell_index),
        .cfg_write     (cfg_write),
        .cfg_data      (cfg_data),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .cursor_column (cursor_column),
        .cursor_row    (cursor_row),
        .cursor_offset (cursor_offset),
        .read_entry    (read_entry),
        .scrolled      (scrolled)
    );

    // A result is only loaded when the output register is empty or draining
    `TTCW_ASSERT(a_load_into_free_slot, !cmd.load || !out_valid || !out_stall, "result overwritten")
    // Once an item is taken, no further item enters until its result is built
    `TTCW_ASSERT_NEXT(a_one_item_in_work, in_valid && !in_stall, in_stall, "second item taken")
    // A scroll always leaves the cursor on the bottom row
    `TTCW_ASSERT(a_scroll_bottom_row, !(out_valid && scrolled) || (cursor_row == ROW_W'(ROWS - 1)), "scroll off bottom row")

endmodule
